// ===== design/asps_pkg.sv =====
// shared types and constants of the adc supply and position smoother
`timescale 1ns / 1ps
`default_nettype none

package asps_pkg;

    // configuration register indexes
    localparam int CFG_IW = 2;
    localparam logic [CFG_IW-1:0] CFG_GATED_MODE     = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_BUS_DIVISOR    = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_POSITION_SCALE = 2'd2;
    localparam int CFG_DW = 16;

    // shared divider sizes
    localparam int DIV_DW = 28;
    localparam int DIV_VW = 16;
    localparam logic [DIV_DW-1:0] SUPPLY_NUM = 28'd5079040;

    localparam int POS_SHIFT = 11;
    localparam int QDEPTH    = 2;

    typedef struct packed {
        logic        gated_mode;
        logic [15:0] bus_divisor;
        logic [14:0] position_scale;
    } t_cfg;

    typedef struct packed {
        logic [11:0]        bus_raw;
        logic [11:0]        temperature_raw;
        logic [11:0]        reference_raw;
        logic signed [15:0] pos;
        logic               update;
    } t_item;

    typedef struct packed {
        logic [15:0]        supply_mv;
        logic [15:0]        bus_mv;
        logic [11:0]        temperature;
        logic signed [15:0] position;
        logic               updated;
    } t_result;

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_VW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_DW-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

// ===== design/adc_supply_position_smoother_core.sv =====
// top level of the adc supply, bus, temperature and position smoother
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------
//  scan    | in        | i_valid / o_stall  | bus, position, temperature, reference, due
//  result  | out       | o_valid / i_stall  | supply_mv, bus_mv, temperature, position,
//          |           |                    | updated
//  config  | in        | i_cfg_we           | i_cfg_idx, i_cfg_data
//
//  a scan that updates goes through the supply division, the bus product, the bus
//  division and, once the filters are loaded, the position average in the back end;
//  a scan without update goes straight to the output; the shared one-bit-per-cycle
//  divider does the supply and bus divisions, the position average a reciprocal multiply
//  the front stage and a two-beat queue keep taking scans while the back end works,
//  and while a result waits on a stalled output, until they fill and o_stall rises
//  synchronous active-low reset clears the filters and the queue and sets the config to defaults
`timescale 1ns / 1ps
`default_nettype none

module adc_supply_position_smoother_core #(
    parameter int POS_AVG_LEN = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [11:0] i_bus_raw,
    input  wire logic [11:0] i_position_raw,
    input  wire logic [11:0] i_temperature_raw,
    input  wire logic [11:0] i_reference_raw,
    input  wire logic        i_sample_due,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_supply_mv,
    output logic [15:0]      o_bus_mv,
    output logic [11:0]      o_temperature,
    output logic signed [15:0] o_position,
    output logic             o_updated,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);
    import asps_pkg::*;

    t_cfg    r_cfg;
    t_item   q_in_item;
    t_item   q_out_item;
    t_result result;
    logic    q_push;
    logic    q_full;
    logic    q_empty;
    logic    q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gated_mode     <= 1'b0;
            r_cfg.bus_divisor    <= 16'd1;
            r_cfg.position_scale <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GATED_MODE:     r_cfg.gated_mode     <= i_cfg_data[0];
                CFG_BUS_DIVISOR:    r_cfg.bus_divisor    <= i_cfg_data;
                CFG_POSITION_SCALE: r_cfg.position_scale <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    asps_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_bus_raw         (i_bus_raw),
        .i_position_raw    (i_position_raw),
        .i_temperature_raw (i_temperature_raw),
        .i_reference_raw   (i_reference_raw),
        .i_sample_due      (i_sample_due),
        .i_q_full          (q_full),
        .o_q_push          (q_push),
        .o_q_item          (q_in_item)
    );

    asps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (q_out_item)
    );

    asps_back #(
        .POS_AVG_LEN (POS_AVG_LEN)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_q_item  (q_out_item),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_result  (result)
    );

    assign o_supply_mv   = result.supply_mv;
    assign o_bus_mv      = result.bus_mv;
    assign o_temperature = result.temperature;
    assign o_position    = result.position;
    assign o_updated     = result.updated;

endmodule

`default_nettype wire

// ===== design/asps_front.sv =====
// front stage: accepts a scan, decides on the update and scales the position
`timescale 1ns / 1ps
`default_nettype none

module asps_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire asps_pkg::t_cfg  i_cfg,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire logic [11:0]     i_bus_raw,
    input  wire logic [11:0]     i_position_raw,
    input  wire logic [11:0]     i_temperature_raw,
    input  wire logic [11:0]     i_reference_raw,
    input  wire logic            i_sample_due,
    input  wire logic            i_q_full,
    output logic                 o_q_push,
    output asps_pkg::t_item      o_q_item
);
    import asps_pkg::*;

    logic        r_valid, n_valid;
    t_item       r_item, n_item;
    logic [26:0] pos_prod;
    logic [16:0] pos_diff;
    logic        accept;

    assign pos_prod = 27'(i_position_raw) * 27'(i_cfg.position_scale);
    assign pos_diff = 17'(pos_prod[26:POS_SHIFT]) - 17'(i_cfg.position_scale);

    assign o_stall  = r_valid && i_q_full;
    assign accept   = i_valid && !o_stall;
    assign o_q_push = r_valid && !i_q_full;
    assign o_q_item = r_item;

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        if (accept) begin
            n_valid                = 1'b1;
            n_item.bus_raw         = i_bus_raw;
            n_item.temperature_raw = i_temperature_raw;
            n_item.reference_raw   = i_reference_raw;
            n_item.pos             = pos_diff[15:0];
            n_item.update          = !i_cfg.gated_mode || i_sample_due;
        end else if (o_q_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

endmodule

`default_nettype wire

// ===== design/asps_queue.sv =====
// short queue between the front stage and the back end
`timescale 1ns / 1ps
`default_nettype none

module asps_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire asps_pkg::t_item i_item,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output asps_pkg::t_item      o_item
);
    import asps_pkg::*;

    localparam int QAW = $clog2(QDEPTH);
    localparam int QCW = $clog2(QDEPTH + 1);

    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wr, n_wr;
    logic [QAW-1:0] r_rd, n_rd;
    logic [QCW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == QCW'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== design/asps_div.sv =====
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module asps_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire asps_pkg::t_div_req i_req,
    output asps_pkg::t_div_rsp      o_rsp
);
    import asps_pkg::*;

    localparam int CW = $clog2(DIV_DW + 1);

    logic              r_busy, n_busy;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [DIV_VW:0]   r_rem, n_rem;
    logic [DIV_DW-1:0] r_quo, n_quo;
    logic [DIV_VW-1:0] r_dsr, n_dsr;
    logic [DIV_VW:0]   rem_sh;
    logic [DIV_VW+1:0] diff;

    assign rem_sh = {r_rem[DIV_VW-1:0], r_quo[DIV_DW-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_dsr};

    assign o_rsp.done = r_busy && (r_cnt == '0);
    assign o_rsp.quot = r_quo;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dsr  = r_dsr;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(DIV_DW);
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_dsr  = i_req.divisor;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt - 1'b1;
                if (!diff[DIV_VW+1]) begin
                    n_rem = diff[DIV_VW:0];
                    n_quo = {r_quo[DIV_DW-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh;
                    n_quo = {r_quo[DIV_DW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
    end

endmodule

`default_nettype wire

// ===== design/asps_back.sv =====
// back end: supply, bus and position arithmetic, filters and result register
`timescale 1ns / 1ps
`default_nettype none

module asps_back #(
    parameter int POS_AVG_LEN = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire asps_pkg::t_cfg  i_cfg,
    input  wire logic            i_q_empty,
    input  wire asps_pkg::t_item i_q_item,
    output logic                 o_q_pop,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output asps_pkg::t_result    o_result
);
    import asps_pkg::*;

    localparam int NUM_W  = 16 + $clog2(POS_AVG_LEN) + 2;
    localparam int RCP_SH = NUM_W + $clog2(POS_AVG_LEN);
    localparam int RCP_W  = NUM_W + 1;
    localparam int PRD_W  = NUM_W + RCP_W;
    localparam logic signed [NUM_W-1:0] PM1   = NUM_W'(POS_AVG_LEN - 1);
    localparam logic signed [NUM_W-1:0] PHALF = NUM_W'(POS_AVG_LEN / 2);
    // rounded-up reciprocal, exact for every NUM_W-bit magnitude
    localparam logic [RCP_W-1:0] RCP_MUL =
        RCP_W'(((64'd1 << RCP_SH) + 64'(POS_AVG_LEN) - 64'd1) / 64'(POS_AVG_LEN));

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_SUP  = 6'b000010,
        B_MUL  = 6'b000100,
        B_BUS  = 6'b001000,
        B_POS  = 6'b010000,
        B_OUT  = 6'b100000
    } t_bstate;

    function automatic logic [15:0] sat16(input logic [DIV_DW-1:0] v);
        return (v[DIV_DW-1:16] != '0) ? 16'hFFFF : v[15:0];
    endfunction

    t_bstate                 r_state, n_state;
    t_item                   r_item, n_item;
    logic [15:0]             r_supply, n_supply;
    logic [15:0]             r_bus, n_bus;
    logic [DIV_DW-1:0]       r_prod, n_prod;
    logic signed [NUM_W-1:0] r_num, n_num;
    logic                    r_num_neg, n_num_neg;
    logic signed [15:0]      r_new_pos, n_new_pos;
    logic [15:0]             r_sup_avg, n_sup_avg;
    logic [15:0]             r_bus_avg, n_bus_avg;
    logic [11:0]             r_tmp_avg, n_tmp_avg;
    logic signed [15:0]      r_pos_avg, n_pos_avg;
    logic                    r_primed, n_primed;
    logic                    r_out_valid, n_out_valid;
    t_result                 r_out, n_out;

    t_div_req                div_req;
    t_div_rsp                div_rsp;
    logic                    out_free;
    logic [NUM_W-1:0]        num_mag;
    logic [PRD_W-1:0]        pos_prod;
    logic [15:0]             pos_quot;
    logic [17:0]             sup_ema;
    logic [17:0]             bus_ema;
    logic [13:0]             tmp_ema;

    asps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign out_free = !r_out_valid || !i_stall;
    assign num_mag  = r_num[NUM_W-1] ? NUM_W'(-r_num) : r_num;
    assign pos_prod = PRD_W'(num_mag) * PRD_W'(RCP_MUL);
    assign pos_quot = pos_prod[RCP_SH +: 16];
    assign sup_ema  = 18'(r_sup_avg) * 18'd3 + 18'(r_supply);
    assign bus_ema  = 18'(r_bus_avg) * 18'd3 + 18'(r_bus);
    assign tmp_ema  = 14'(r_tmp_avg) * 14'd3 + 14'(r_item.temperature_raw);

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_supply    = r_supply;
        n_bus       = r_bus;
        n_prod      = r_prod;
        n_num       = r_num;
        n_num_neg   = r_num_neg;
        n_new_pos   = r_new_pos;
        n_sup_avg   = r_sup_avg;
        n_bus_avg   = r_bus_avg;
        n_tmp_avg   = r_tmp_avg;
        n_pos_avg   = r_pos_avg;
        n_primed    = r_primed;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_q_pop     = 1'b0;
        div_req     = '{start: 1'b0, dividend: '0, divisor: '0};

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_item  = i_q_item;
                    if (i_q_item.update) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = SUPPLY_NUM;
                        div_req.divisor  = DIV_VW'(i_q_item.reference_raw);
                        n_state          = B_SUP;
                    end else begin
                        n_state = B_OUT;
                    end
                end
            end
            B_SUP: begin
                if (div_rsp.done) begin
                    n_supply = sat16(div_rsp.quot);
                    n_prod   = DIV_DW'(r_item.bus_raw) * DIV_DW'(n_supply);
                    n_state  = B_MUL;
                end
            end
            B_MUL: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_prod;
                div_req.divisor  = i_cfg.bus_divisor;
                n_num   = NUM_W'(r_pos_avg) * PM1 + NUM_W'(signed'(r_item.pos)) + PHALF;
                n_state = B_BUS;
            end
            B_BUS: begin
                if (div_rsp.done) begin
                    n_bus = sat16(div_rsp.quot);
                    if (r_primed) begin
                        n_num_neg = r_num[NUM_W-1];
                        n_state   = B_POS;
                    end else begin
                        n_new_pos = r_item.pos;
                        n_state   = B_OUT;
                    end
                end
            end
            B_POS: begin
                // truncation toward zero: scale the magnitude, then restore the sign
                n_new_pos = r_num_neg ? (16'd0 - pos_quot) : pos_quot;
                n_state   = B_OUT;
            end
            B_OUT: begin
                if (out_free) begin
                    if (r_item.update) begin
                        if (r_primed) begin
                            n_sup_avg = sup_ema[17:2];
                            n_bus_avg = bus_ema[17:2];
                            n_tmp_avg = tmp_ema[13:2];
                        end else begin
                            n_sup_avg = r_supply;
                            n_bus_avg = r_bus;
                            n_tmp_avg = r_item.temperature_raw;
                        end
                        n_pos_avg = r_new_pos;
                        n_primed  = 1'b1;
                    end
                    n_out_valid = 1'b1;
                    n_out       = '{supply_mv:   n_sup_avg,
                                    bus_mv:      n_bus_avg,
                                    temperature: n_tmp_avg,
                                    position:    n_pos_avg,
                                    updated:     r_item.update};
                    n_state     = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_sup_avg   <= '0;
            r_bus_avg   <= '0;
            r_tmp_avg   <= '0;
            r_pos_avg   <= '0;
            r_primed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sup_avg   <= n_sup_avg;
            r_bus_avg   <= n_bus_avg;
            r_tmp_avg   <= n_tmp_avg;
            r_pos_avg   <= n_pos_avg;
            r_primed    <= n_primed;
            r_out_valid <= n_out_valid;
        end
        r_item    <= n_item;
        r_supply  <= n_supply;
        r_bus     <= n_bus;
        r_prod    <= n_prod;
        r_num     <= n_num;
        r_num_neg <= n_num_neg;
        r_new_pos <= n_new_pos;
        r_out     <= n_out;
    end

    a_primed_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_primed |=> r_primed)
        else $error("filters fell back to unloaded");

    a_div_done_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == B_SUP || r_state == B_BUS))
        else $error("divider finished with no one waiting");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> !i_q_empty)
        else $error("pop from empty queue");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_OUT && out_free) |=> (o_valid && r_state == B_IDLE))
        else $error("committed result not presented");

endmodule

`default_nettype wire
